/* rtl/bhp_pkg.sv */
// ----------------------------------------------------------------------------
// bhp_pkg
// Types and codes shared by the bitstream header parser modules.
// ----------------------------------------------------------------------------
package bhp_pkg;

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_MLHI  = 5'd1;
  localparam logic [4:0] PH_MLLO  = 5'd2;
  localparam logic [4:0] PH_MAGIC = 5'd3;
  localparam logic [4:0] PH_NULL  = 5'd4;
  localparam logic [4:0] PH_SEPHI = 5'd5;
  localparam logic [4:0] PH_SEPLO = 5'd6;
  localparam logic [4:0] PH_KEY   = 5'd7;
  localparam logic [4:0] PH_LENHI = 5'd12;
  localparam logic [4:0] PH_LENLO = 5'd16;
  localparam logic [4:0] PH_TEXT  = 5'd20;
  localparam logic [4:0] PH_PAY   = 5'd24;
  localparam logic [4:0] PH_END   = 5'd28;

  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  localparam logic [2:0] SEC_MAGIC_LEN = 3'd0;
  localparam logic [2:0] SEC_MAGIC     = 3'd1;
  localparam logic [2:0] SEC_KEY       = 3'd2;
  localparam logic [2:0] SEC_DESIGN    = 3'd3;
  localparam logic [2:0] SEC_LENGTH    = 3'd7;

  localparam logic [7:0]  MAGIC_EVEN = 8'h0f;
  localparam logic [7:0]  MAGIC_ODD  = 8'hf0;
  localparam logic [15:0] SEP_WORD   = 16'h0001;
  localparam logic [7:0]  KEY_FIRST  = 8'h61;
  localparam logic [2:0]  KEY_COUNT  = 3'd4;

  typedef struct packed {
    logic [4:0]  phase;
    logic [15:0] bytes_left;
    logic        magic_odd;
    logic [18:0] byte_pos;
    logic [31:0] acc;
  } bhp_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  section;
    logic        text_valid;
    logic [7:0]  text_byte;
    logic [18:0] header_bytes;
    logic [31:0] payload_bytes;
  } bhp_result_t;

endpackage

/* rtl/bitstream_header_parser.sv */
// ----------------------------------------------------------------------------
// bitstream_header_parser
// Parses a configuration-file header one byte per item and labels each byte.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one result item in the next cycle, and a
// new byte is taken every clock except while a held result waits on
// out_stall: the parse step is a single layer of logic between the state
// register and the result register. A byte with in_restart set begins a new
// file; after completion or an error the block reports idle until then.
module bitstream_header_parser import bhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_section,
  output logic        out_text_valid,
  output logic [7:0]  out_text_byte,
  output logic [18:0] out_header_bytes,
  output logic [31:0] out_payload_bytes
);

  bhp_state_t  state_r;
  bhp_state_t  state_nxt;
  bhp_result_t res_r;
  bhp_result_t res_nxt;
  logic        valid_r;
  logic        accept;

  assign in_stall = valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  bhp_step u_step (
    .cur       (state_r),
    .data_byte (in_data_byte),
    .restart   (in_restart),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, bytes_left: '0, magic_odd: 1'b0,
                   byte_pos: '0, acc: '0};
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = res_r.status;
  assign out_section       = res_r.section;
  assign out_text_valid    = res_r.text_valid;
  assign out_text_byte     = res_r.text_byte;
  assign out_header_bytes  = res_r.header_bytes;
  assign out_payload_bytes = res_r.payload_bytes;

endmodule

/* rtl/bhp_step.sv */
// ----------------------------------------------------------------------------
// bhp_step
// Next-state and result logic for one header byte.
// ----------------------------------------------------------------------------
module bhp_step import bhp_pkg::*; (
  input  bhp_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output bhp_state_t  nxt,
  output bhp_result_t res
);

  bhp_state_t  st;
  logic        err;
  logic [15:0] len;
  logic [15:0] left_dec;
  logic [2:0]  key_k;
  logic [1:0]  k;
  logic [31:0] acc_sh;

  always_comb begin
    st = cur;
    if (restart) begin
      st.phase      = PH_MLHI;
      st.bytes_left = '0;
      st.magic_odd  = 1'b0;
      st.byte_pos   = '0;
      st.acc        = '0;
    end

    nxt      = st;
    res      = '0;
    err      = 1'b0;
    len      = {st.acc[7:0], data_byte};
    left_dec = st.bytes_left - 16'd1;
    key_k    = 3'(st.phase - PH_KEY);
    k        = st.phase[1:0];
    acc_sh   = {st.acc[23:0], data_byte};

    if (st.phase == PH_IDLE || st.phase >= PH_END) begin
      nxt.phase  = PH_IDLE;
      res.status = ST_IDLE;
    end else begin
      res.status   = ST_PARSING;
      nxt.byte_pos = st.byte_pos + 19'd1;
      if (st.phase == PH_MLHI) begin
        res.section = SEC_MAGIC_LEN;
        nxt.acc     = {24'd0, data_byte};
        nxt.phase   = PH_MLLO;
      end else if (st.phase == PH_MLLO) begin
        res.section = SEC_MAGIC_LEN;
        if (len == 16'd0) begin
          err = 1'b1;
        end else begin
          nxt.bytes_left = len - 16'd1;
          nxt.magic_odd  = 1'b0;
          nxt.phase      = (len != 16'd1) ? PH_MAGIC : PH_NULL;
        end
      end else if (st.phase == PH_MAGIC) begin
        res.section = SEC_MAGIC;
        if (data_byte != (st.magic_odd ? MAGIC_ODD : MAGIC_EVEN)) begin
          err = 1'b1;
        end else begin
          nxt.magic_odd  = ~st.magic_odd;
          nxt.bytes_left = left_dec;
          if (left_dec == 16'd0) begin
            nxt.phase = PH_NULL;
          end
        end
      end else if (st.phase == PH_NULL) begin
        res.section = SEC_MAGIC;
        nxt.phase   = PH_SEPHI;
      end else if (st.phase == PH_SEPHI) begin
        res.section = SEC_KEY;
        nxt.acc     = {24'd0, data_byte};
        nxt.phase   = PH_SEPLO;
      end else if (st.phase == PH_SEPLO) begin
        res.section = SEC_KEY;
        if (len != SEP_WORD) begin
          err = 1'b1;
        end else begin
          nxt.phase = PH_KEY;
        end
      end else if (st.phase < PH_LENHI) begin
        res.section = SEC_KEY;
        if (data_byte != KEY_FIRST + 8'(key_k)) begin
          err = 1'b1;
        end else if (key_k == KEY_COUNT) begin
          nxt.acc   = '0;
          nxt.phase = PH_PAY;
        end else begin
          nxt.phase = PH_LENHI + 5'(key_k);
        end
      end else if (st.phase < PH_LENLO) begin
        res.section = SEC_DESIGN + 3'(k);
        nxt.acc     = {24'd0, data_byte};
        nxt.phase   = PH_LENLO + 5'(k);
      end else if (st.phase < PH_TEXT) begin
        res.section    = SEC_DESIGN + 3'(k);
        nxt.bytes_left = len;
        nxt.phase      = (len != 16'd0) ? PH_TEXT + 5'(k) : PH_KEY + 5'(k) + 5'd1;
      end else if (st.phase < PH_PAY) begin
        res.section    = SEC_DESIGN + 3'(k);
        res.text_valid = 1'b1;
        res.text_byte  = data_byte;
        nxt.bytes_left = left_dec;
        if (left_dec == 16'd0) begin
          nxt.phase = PH_KEY + 5'(k) + 5'd1;
        end
      end else begin
        res.section = SEC_LENGTH;
        nxt.acc     = acc_sh;
        if (k != 2'd3) begin
          nxt.phase = st.phase + 5'd1;
        end else begin
          res.status        = ST_DONE;
          res.header_bytes  = st.byte_pos + 19'd1;
          res.payload_bytes = acc_sh;
          nxt.phase         = PH_IDLE;
        end
      end
      if (err) begin
        res.status = ST_ERROR;
        nxt.phase  = PH_IDLE;
      end
    end
  end

endmodule
